@@ hw/rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and constants for the character stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

   // Field widths fixed by the item formats
   localparam int CHAR_BITS  = 8;
   localparam int KIND_BITS  = 4;
   localparam int ERR_BITS   = 2;
   localparam int TPOS_BITS  = 16;
   localparam int CLASS_BITS = 4;

   localparam int POSITION_BITS_DEFAULT = 16;

   // Front/back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_SLASH   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_STAR    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_SEMI    = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 4'd11;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 4'd12;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd13;
   localparam logic [KIND_BITS-1:0] KIND_KEYWORD = 4'd14;
   localparam logic [KIND_BITS-1:0] KIND_ERROR   = 4'd15;

   // Error codes
   localparam logic [ERR_BITS-1:0] ERR_NONE   = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_NUMBER = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_CHAR   = 2'd2;

   // Character classes produced by the front end
   localparam logic [CLASS_BITS-1:0] CLS_NEWLINE = 4'd0;
   localparam logic [CLASS_BITS-1:0] CLS_SPACE   = 4'd1;
   localparam logic [CLASS_BITS-1:0] CLS_EOF     = 4'd2;
   localparam logic [CLASS_BITS-1:0] CLS_HASH    = 4'd3;
   localparam logic [CLASS_BITS-1:0] CLS_PUNCT   = 4'd4;
   localparam logic [CLASS_BITS-1:0] CLS_DIGIT   = 4'd5;
   localparam logic [CLASS_BITS-1:0] CLS_DOT     = 4'd6;
   localparam logic [CLASS_BITS-1:0] CLS_ALPHA   = 4'd7;
   localparam logic [CLASS_BITS-1:0] CLS_OTHER   = 4'd8;

   // Special characters
   localparam logic [CHAR_BITS-1:0] CHAR_NUL        = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_BS         = 8'h08;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB        = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_NL         = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_FF         = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CHAR_CR         = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE      = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_HASH       = 8'h23;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5F;

   // Keyword "float"
   localparam int KEYWORD_LEN = 5;

   function automatic logic [CHAR_BITS-1:0] keyword_char(input logic [2:0] idx);
      logic [CHAR_BITS-1:0] c;
      unique case (idx)
         3'd0:    c = 8'h66;  // f
         3'd1:    c = 8'h6C;  // l
         3'd2:    c = 8'h6F;  // o
         3'd3:    c = 8'h61;  // a
         3'd4:    c = 8'h74;  // t
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // One classified byte in the front/back queue
   typedef struct packed {
      logic [CHAR_BITS-1:0]  ch;
      logic [CLASS_BITS-1:0] cls;
      logic [KIND_BITS-1:0]  pkind;
   } qentry_type;

   // One result item
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ERR_BITS-1:0]  error_code;
      logic [CHAR_BITS-1:0] char_value;
      logic [TPOS_BITS-1:0] tok_line;
      logic [TPOS_BITS-1:0] tok_column;
      logic [TPOS_BITS-1:0] tok_length;
      logic                 last_of_run;
   } tok_type;

endpackage

`default_nettype wire

@@ hw/rtl/cst_chan_if.sv @@
// ----------------------------------------------------------------------------
// cst_chan_if
// Valid/ready channels: source bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_byte_if;
   import cst_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface cst_tok_if;
   import cst_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [ERR_BITS-1:0]  error_code;
   logic [CHAR_BITS-1:0] char_value;
   logic [TPOS_BITS-1:0] tok_line;
   logic [TPOS_BITS-1:0] tok_column;
   logic [TPOS_BITS-1:0] tok_length;
   logic                 last_of_run;

   modport source (output valid, output kind, output error_code, output char_value,
                   output tok_line, output tok_column, output tok_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input error_code, input char_value,
                   input tok_line, input tok_column, input tok_length,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cst_front.sv @@
// ----------------------------------------------------------------------------
// cst_front
// Accept source bytes and classify them for the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_front (
   cst_byte_if.sink           req_chan,
   input  wire logic          q_full,
   output logic               q_push,
   output cst_pkg::qentry_type q_data
);
   import cst_pkg::*;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      q_data.ch    = req_chan.ch;
      q_data.pkind = KIND_EOF;
      unique case (req_chan.ch) inside
         CHAR_NL:                                      q_data.cls = CLS_NEWLINE;
         CHAR_SPACE, CHAR_TAB, CHAR_FF, CHAR_BS, CHAR_CR: q_data.cls = CLS_SPACE;
         CHAR_NUL:                                     q_data.cls = CLS_EOF;
         CHAR_HASH:                                    q_data.cls = CLS_HASH;
         CHAR_DOT:                                     q_data.cls = CLS_DOT;
         [8'h30:8'h39]:                                q_data.cls = CLS_DIGIT;
         [8'h41:8'h5A], [8'h61:8'h7A], CHAR_UNDERSCORE: q_data.cls = CLS_ALPHA;
         default:                                      q_data.cls = CLS_OTHER;
      endcase
      // Single-character tokens
      unique case (req_chan.ch)
         8'h29:   q_data.pkind = KIND_RPAREN;
         8'h28:   q_data.pkind = KIND_LPAREN;
         8'h2B:   q_data.pkind = KIND_PLUS;
         8'h2D:   q_data.pkind = KIND_MINUS;
         8'h2F:   q_data.pkind = KIND_SLASH;
         8'h2A:   q_data.pkind = KIND_STAR;
         8'h3B:   q_data.pkind = KIND_SEMI;
         8'h7B:   q_data.pkind = KIND_LBRACE;
         8'h7D:   q_data.pkind = KIND_RBRACE;
         8'h2C:   q_data.pkind = KIND_COMMA;
         8'h3D:   q_data.pkind = KIND_ASSIGN;
         default: q_data.pkind = KIND_EOF;
      endcase
      if (q_data.pkind != KIND_EOF) begin
         q_data.cls = CLS_PUNCT;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cst_queue.sv @@
// ----------------------------------------------------------------------------
// cst_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cst_pkg::qentry_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output cst_pkg::qentry_type     pop_data,
   output logic                    empty
);
   import cst_pkg::*;

   qentry_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cst_back.sv @@
// ----------------------------------------------------------------------------
// cst_back
// Scanner state machine and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_back #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire cst_pkg::qentry_type q_data,
   output logic                     q_pop,
   cst_tok_if.source                rsp_chan
);
   import cst_pkg::*;

   localparam int PB = POSITION_BITS;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_NUM     = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_COMMENT = 3'd3;
   localparam logic [2:0] MODE_HALT    = 3'd4;
   localparam logic [2:0] MODE_DONE    = 3'd5;

   localparam logic [PB-1:0] POS_ONE = PB'(1);
   localparam logic [PB-1:0] POS_KW  = PB'(KEYWORD_LEN);

   function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
      return (&v) ? v : v + POS_ONE;
   endfunction

   // Clamp a position to the 16-bit result field
   function automatic logic [TPOS_BITS-1:0] to_out(input logic [PB-1:0] v);
      logic [PB+TPOS_BITS-1:0] wide;
      wide = {{TPOS_BITS{1'b0}}, v};
      return (wide[PB+TPOS_BITS-1:TPOS_BITS] != '0) ? {TPOS_BITS{1'b1}}
                                                    : wide[TPOS_BITS-1:0];
   endfunction

   function automatic tok_type make_tok(input logic [KIND_BITS-1:0] kind,
                                        input logic [ERR_BITS-1:0]  err,
                                        input logic [CHAR_BITS-1:0] chv,
                                        input logic [PB-1:0]        line,
                                        input logic [PB-1:0]        col,
                                        input logic [PB-1:0]        len);
      tok_type t;
      t.kind        = kind;
      t.error_code  = err;
      t.char_value  = chv;
      t.tok_line    = to_out(line);
      t.tok_column  = to_out(col);
      t.tok_length  = to_out(len);
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // Scanner state
   logic [2:0]    mode_ff,  mode_in;
   logic [PB-1:0] line_ff,  line_in;
   logic [PB-1:0] col_ff,   col_in;
   logic [PB-1:0] start_ff, start_in;
   logic [PB-1:0] len_ff,   len_in;
   logic          dot_ff,   dot_in;
   logic [2:0]    kwp_ff,   kwp_in;
   logic          kwf_ff,   kwf_in;

   // Result registers
   logic    out_valid_ff, out_valid_in;
   tok_type out_data_ff,  out_data_in;
   logic    sec_valid_ff, sec_valid_in;
   tok_type sec_data_ff,  sec_data_in;

   logic          out_free;
   logic [PB-1:0] col_inc;
   logic          run_idle, is_kw;
   logic          a_valid, b_valid;
   tok_type       a_data, b_data, first_data;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign q_pop    = !q_empty && out_free && !sec_valid_ff;
   assign col_inc  = sat_inc(col_ff);
   assign is_kw    = !kwf_ff && (kwp_ff == 3'(KEYWORD_LEN)) && (len_ff == POS_KW);

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      kwp_in   = kwp_ff;
      kwf_in   = kwf_ff;
      run_idle = 1'b0;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      a_data   = '0;
      b_data   = '0;

      unique case (mode_ff)
         MODE_IDLE: begin
            run_idle = 1'b1;
         end
         MODE_NUM: begin
            if (q_data.cls == CLS_DIGIT || q_data.cls == CLS_DOT) begin
               col_in = col_inc;
               if (q_data.cls == CLS_DOT && dot_ff) begin
                  a_valid = 1'b1;
                  a_data  = make_tok(KIND_ERROR, ERR_NUMBER, q_data.ch, line_ff,
                                     col_inc, POS_ONE);
                  mode_in = MODE_HALT;
               end else begin
                  dot_in = dot_ff || (q_data.cls == CLS_DOT);
                  len_in = sat_inc(len_ff);
               end
            end else begin
               a_valid  = 1'b1;
               a_data   = make_tok(KIND_NUMBER, ERR_NONE, CHAR_NUL, line_ff,
                                   start_ff, len_ff);
               mode_in  = MODE_IDLE;
               run_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (q_data.cls == CLS_ALPHA || q_data.cls == CLS_DIGIT) begin
               col_in = col_inc;
               if (len_ff < POS_KW && q_data.ch == keyword_char(len_ff[2:0])) begin
                  kwp_in = kwp_ff + 1'b1;
               end else begin
                  kwf_in = 1'b1;
               end
               len_in = sat_inc(len_ff);
            end else begin
               a_valid  = 1'b1;
               a_data   = make_tok(is_kw ? KIND_KEYWORD : KIND_IDENT, ERR_NONE,
                                   CHAR_NUL, line_ff, start_ff, len_ff);
               mode_in  = MODE_IDLE;
               run_idle = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (q_data.cls == CLS_NEWLINE || q_data.cls == CLS_EOF) begin
               mode_in  = MODE_IDLE;
               run_idle = 1'b1;
            end else begin
               col_in = col_inc;
            end
         end
         default: begin
            // halted, done and unused codes: drop the byte
         end
      endcase

      if (run_idle) begin
         if (q_data.cls == CLS_NEWLINE) begin
            col_in  = '0;
            line_in = sat_inc(line_ff);
         end else begin
            col_in = col_inc;
            unique case (q_data.cls) inside
               CLS_EOF: begin
                  b_valid = 1'b1;
                  b_data  = make_tok(KIND_EOF, ERR_NONE, CHAR_NUL, line_ff,
                                     col_inc, '0);
                  mode_in = MODE_DONE;
               end
               CLS_HASH: begin
                  mode_in = MODE_COMMENT;
               end
               CLS_PUNCT: begin
                  b_valid = 1'b1;
                  b_data  = make_tok(q_data.pkind, ERR_NONE, q_data.ch, line_ff,
                                     col_inc, POS_ONE);
               end
               CLS_DIGIT, CLS_DOT: begin
                  mode_in  = MODE_NUM;
                  start_in = col_inc;
                  len_in   = POS_ONE;
                  dot_in   = (q_data.cls == CLS_DOT);
               end
               CLS_ALPHA: begin
                  mode_in  = MODE_IDENT;
                  start_in = col_inc;
                  len_in   = POS_ONE;
                  kwp_in   = (q_data.ch == keyword_char(3'd0)) ? 3'd1 : 3'd0;
                  kwf_in   = (q_data.ch != keyword_char(3'd0));
               end
               CLS_OTHER: begin
                  b_valid = 1'b1;
                  b_data  = make_tok(KIND_ERROR, ERR_CHAR, q_data.ch, line_ff,
                                     col_inc, POS_ONE);
               end
               default: begin
                  // whitespace: skip
               end
            endcase
         end
      end

      first_data             = a_valid ? a_data : b_data;
      first_data.last_of_run = !(a_valid && b_valid);
      b_data.last_of_run     = 1'b1;
   end

   // Result registers: a second result waits in its own slot
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      sec_valid_in = sec_valid_ff;
      sec_data_in  = sec_data_ff;
      if (out_free) begin
         if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = sec_data_ff;
            sec_valid_in = 1'b0;
         end else if (q_pop && (a_valid || b_valid)) begin
            out_valid_in = 1'b1;
            out_data_in  = first_data;
            sec_valid_in = a_valid && b_valid;
            sec_data_in  = b_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         line_ff      <= POS_ONE;
         col_ff       <= '0;
         start_ff     <= '0;
         len_ff       <= '0;
         dot_ff       <= 1'b0;
         kwp_ff       <= '0;
         kwf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            mode_ff  <= mode_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            dot_ff   <= dot_in;
            kwp_ff   <= kwp_in;
            kwf_ff   <= kwf_in;
         end
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      sec_data_ff <= sec_data_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_data_ff.kind;
   assign rsp_chan.error_code  = out_data_ff.error_code;
   assign rsp_chan.char_value  = out_data_ff.char_value;
   assign rsp_chan.tok_line    = out_data_ff.tok_line;
   assign rsp_chan.tok_column  = out_data_ff.tok_column;
   assign rsp_chan.tok_length  = out_data_ff.tok_length;
   assign rsp_chan.last_of_run = out_data_ff.last_of_run;

endmodule

`default_nettype wire

@@ hw/rtl/char_stream_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Byte-stream lexer: source text in, positioned tokens out.
// ----------------------------------------------------------------------------
// Feed source text one byte per item on req_chan; a zero byte ends the
// stream. Tokens come out on rsp_chan with kind, error code, character (for
// single-character tokens and errors), line, one-based start column and
// length, all clamped to 16 bits. A byte that closes a number or identifier
// and is itself a token yields two items; last_of_run marks the final item
// of each byte. The block takes one byte per cycle while each byte gives at
// most one token and the output is not stalled; a byte that gives two
// holds the scanner until its second token moves into the result register,
// since that register delivers one token per cycle. A front end classifies
// bytes into a four-entry queue, so input keeps flowing during short output
// stalls. After the end-of-input token, or after a second dot in a number
// (reported as an error), further bytes are accepted and dropped until
// reset. Line and column counters are POSITION_BITS wide and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_tokenizer_top #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   cst_byte_if.sink  req_chan,
   cst_tok_if.source rsp_chan
);
   import cst_pkg::*;

   // Front to queue
   logic       push;
   qentry_type push_data;
   logic       q_full;

   // Queue to back
   logic       pop;
   qentry_type pop_data;
   logic       q_empty;

   // Classify and accept bytes
   cst_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (push),
      .q_data   (push_data)
   );

   // Decouple the two halves
   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // Scan and emit tokens
   cst_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (pop_data),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
